/* sv/cdn_pkg.sv */
// Shared types, constants and calendar helpers for the day number converter.
// No dependencies; every other file in this folder imports it.

package cdn_pkg;

	localparam logic [11:0] EPOCH_YEAR    = 12'd2000;
	localparam logic [11:0] LAST_YEAR     = 12'd2099;
	localparam logic [15:0] DAY_LIMIT     = 16'd36525;
	localparam logic [15:0] CYCLE_DAYS    = 16'd1461;
	// floor(2^22 / 1461): quotient estimate is never high and at most one low
	localparam logic [27:0] CYCLE_RECIP   = 28'd2870;
	localparam int          RECIP_SHIFT   = 22;
	localparam logic [16:0] EPOCH_WEEKDAY = 17'd5;
	localparam logic [0:0]  FUNC_TO_NUM   = 1'b0;
	localparam logic [0:0]  FUNC_TO_DATE  = 1'b1;

	typedef struct packed {
		logic        func;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] day_number;
	} cmd_word_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] day_count;
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  weekday;
	} rsp_word_t;

	// Working set carried down the pipeline; each stage fills in its part.
	typedef struct packed {
		logic        func;
		logic        ok;
		logic [6:0]  yo;
		logic        leap;
		logic [3:0]  mon;
		logic [4:0]  dom;
		logic [8:0]  doy;
		logic [15:0] num;
		logic [5:0]  q;
		logic [10:0] r;
		logic [2:0]  wd;
	} pipe_word_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m.
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && (m > 4'd2) && (m <= 4'd12))
			s = s + 9'd1;
		return s;
	endfunction

	// Residue mod 7 by folding octal digits (8 = 1 mod 7).
	function automatic logic [2:0] mod7(input logic [16:0] x);
		logic [5:0] s;
		logic [3:0] t;
		s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
			+ 6'(x[16:15]);
		t = 4'(s[2:0]) + 4'(s[5:3]);
		if (t >= 4'd7)
			t = t - 4'd7;
		return t[2:0];
	endfunction

endpackage

/* sv/cdn_datapath.sv */
// Four-stage conversion datapath: date to day number and day number to date.
// Depends on cdn_pkg; stage enables come from the handshake logic in the top level.

module cdn_datapath import cdn_pkg::*; (
	input  logic      clk,
	input  logic [3:0] en,
	input  cmd_word_t cmd,
	output rsp_word_t rsp
);

	pipe_word_t pipe_s1, pipe_s2, pipe_s3;
	rsp_word_t  rsp_s4;
	pipe_word_t nxt1, nxt2, nxt3;
	rsp_word_t  nxt4;

	logic [11:0] yoff;
	logic        yr_ok, leap0, date_ok;
	logic [4:0]  mlen;
	logic [27:0] prod;
	logic [15:0] rdiff;
	logic [3:0]  mon4;

	// Stage 1: range checks, day of year, cycle estimate
	always_comb begin
		yoff    = cmd.year - EPOCH_YEAR;
		yr_ok   = (cmd.year >= EPOCH_YEAR) && (cmd.year <= LAST_YEAR);
		leap0   = (yoff[1:0] == 2'b00);
		mlen    = month_len(cmd.month, leap0);
		date_ok = yr_ok && (mlen != 5'd0) && (cmd.day != 5'd0) && (cmd.day <= mlen);
		prod    = 28'(cmd.day_number) * CYCLE_RECIP;
		nxt1.func = cmd.func;
		nxt1.ok   = (cmd.func == FUNC_TO_DATE) ? (cmd.day_number < DAY_LIMIT) : date_ok;
		nxt1.yo   = yoff[6:0];
		nxt1.leap = leap0;
		nxt1.mon  = cmd.month;
		nxt1.dom  = cmd.day;
		nxt1.doy  = month_start(cmd.month, leap0) + 9'(cmd.day) - 9'd1;
		nxt1.num  = cmd.day_number;
		nxt1.q    = prod[RECIP_SHIFT +: 6];
		nxt1.r    = '0;
		nxt1.wd   = '0;
	end

	// Stage 2: whole day number of a date, or remainder within the four-year cycle
	always_comb begin
		nxt2  = pipe_s1;
		rdiff = pipe_s1.num - 16'(pipe_s1.q) * CYCLE_DAYS;
		if (pipe_s1.func == FUNC_TO_NUM) begin
			nxt2.num = 16'(pipe_s1.yo) * 16'd365
				+ 16'((8'(pipe_s1.yo) + 8'd3) >> 2)
				+ 16'(pipe_s1.doy);
		end else if (rdiff >= CYCLE_DAYS) begin
			nxt2.q = pipe_s1.q + 6'd1;
			nxt2.r = 11'(rdiff - CYCLE_DAYS);
		end else begin
			nxt2.r = rdiff[10:0];
		end
	end

	// Stage 3: year within the cycle, weekday
	always_comb begin
		nxt3    = pipe_s2;
		nxt3.wd = mod7(17'(pipe_s2.num) + EPOCH_WEEKDAY);
		if (pipe_s2.func == FUNC_TO_DATE) begin
			if (pipe_s2.r < 11'd366) begin
				nxt3.yo  = 7'({pipe_s2.q, 2'd0});
				nxt3.doy = pipe_s2.r[8:0];
			end else if (pipe_s2.r < 11'd731) begin
				nxt3.yo  = 7'({pipe_s2.q, 2'd1});
				nxt3.doy = 9'(pipe_s2.r - 11'd366);
			end else if (pipe_s2.r < 11'd1096) begin
				nxt3.yo  = 7'({pipe_s2.q, 2'd2});
				nxt3.doy = 9'(pipe_s2.r - 11'd731);
			end else begin
				nxt3.yo  = 7'({pipe_s2.q, 2'd3});
				nxt3.doy = 9'(pipe_s2.r - 11'd1096);
			end
			nxt3.leap = (pipe_s2.r < 11'd366);
		end
	end

	// Stage 4: month search and result formatting
	always_comb begin
		mon4 = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (pipe_s3.doy >= month_start(4'(k), pipe_s3.leap))
				mon4 = 4'(k);
		end
		nxt4 = '0;
		if (pipe_s3.ok) begin
			nxt4.valid_res = 1'b1;
			nxt4.day_count = pipe_s3.num;
			nxt4.out_year  = EPOCH_YEAR + 12'(pipe_s3.yo);
			nxt4.weekday   = pipe_s3.wd;
			if (pipe_s3.func == FUNC_TO_DATE) begin
				nxt4.out_month = mon4;
				nxt4.out_day   = 5'(pipe_s3.doy - month_start(mon4, pipe_s3.leap) + 9'd1);
			end else begin
				nxt4.out_month = pipe_s3.mon;
				nxt4.out_day   = pipe_s3.dom;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) pipe_s1 <= nxt1;
		if (en[1]) pipe_s2 <= nxt2;
		if (en[2]) pipe_s3 <= nxt3;
		if (en[3]) rsp_s4  <= nxt4;
	end

	assign rsp = rsp_s4;

endmodule

/* sv/calendar_day_number_converter.sv */
// Top level of the calendar day number converter: handshake and valid pipeline.
// Depends on cdn_pkg and cdn_datapath.
//
// Usage:
//   The cmd channel takes one word per accepted handshake (cmd_valid high,
//   cmd_stall low). func selects the direction: date to day number, or day
//   number to date, over 2000-01-01 (day 0) to 2099-12-31.
//   The rsp channel returns exactly one word per command, in order. A date that
//   does not exist or a day number past the range gives valid_res low and all
//   other fields zero; otherwise every field is filled, weekday Monday = 0.
// Timing:
//   A word passes through four register stages (range check, day arithmetic,
//   year split and weekday, month search) from the accepting edge to rsp_valid.
//   Throughput is one word per cycle while the receiver keeps rsp_stall low.
// Stall:
//   Each stage holds its word when the stage ahead is full and stalled; empty
//   stages still advance, so bubbles are squeezed out. cmd_stall rises only when
//   all four stages hold a word and the output word is being stalled.
// Reset:
//   arst_n clears every valid bit at once; the datapath registers carry no reset.

module calendar_day_number_converter import cdn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	logic       vld_s1, vld_s2, vld_s3, vld_s4;
	logic [3:0] en;

	// Advance a stage when it is empty or the stage ahead will take its word
	assign en[3] = !vld_s4 || !rsp_stall;
	assign en[2] = !vld_s3 || en[3];
	assign en[1] = !vld_s2 || en[2];
	assign en[0] = !vld_s1 || en[1];

	assign cmd_stall = !en[0];
	assign rsp_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en[0]) vld_s1 <= cmd_valid;
			if (en[1]) vld_s2 <= vld_s1;
			if (en[2]) vld_s3 <= vld_s2;
			if (en[3]) vld_s4 <= vld_s3;
		end
	end

	cdn_datapath u_datapath (
		.clk (clk),
		.en  (en),
		.cmd (cmd),
		.rsp (rsp)
	);

	// Back-pressure reaches the input only with the pipeline full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && rsp_stall))
		else $error("cmd_stall raised with a free stage");

	// A rejected conversion carries an all-zero word
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.valid_res) |->
			(rsp.day_count == 16'd0 && rsp.out_year == 12'd0 && rsp.out_month == 4'd0
			 && rsp.out_day == 5'd0 && rsp.weekday == 3'd0))
		else $error("invalid result with non-zero fields");

	// An accepted conversion stays inside the calendar range
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.valid_res) |->
			(rsp.day_count < DAY_LIMIT && rsp.out_year >= EPOCH_YEAR
			 && rsp.out_year <= LAST_YEAR && rsp.out_month >= 4'd1
			 && rsp.out_month <= 4'd12 && rsp.out_day != 5'd0 && rsp.weekday <= 3'd6))
		else $error("valid result outside calendar range");

	// Stage three keeps its valid bit while it cannot advance
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !en[2]) |=> vld_s3)
		else $error("stage three dropped a held word");

endmodule

/* verif/day_number_checker.sv */
// Checker for the calendar day number converter: watches both channels, predicts each
// response word from the accepted command word and compares field by field.
// Depends on cdn_pkg for the word types and the epoch constants.

module day_number_checker import cdn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_stall,
	input  cmd_word_t cmd,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	rsp_word_t expected_words[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_year(input int unsigned y);
		return is_leap(y) ? 366 : 365;
	endfunction

	// Zero for a month outside 1..12.
	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		int unsigned len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = is_leap(y) ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	function automatic rsp_word_t convert_calendar(input cmd_word_t w);
		rsp_word_t r;
		int unsigned yr, mo, dy, num, left, k;
		r = '0;
		if (w.func == FUNC_TO_NUM) begin
			yr = 32'(w.year);
			mo = 32'(w.month);
			dy = 32'(w.day);
			if (yr < 32'(EPOCH_YEAR) || yr > 32'(LAST_YEAR))
				return r;
			if (days_in_month(yr, mo) == 0 || dy < 1 || dy > days_in_month(yr, mo))
				return r;
			num = dy - 1;
			for (k = 32'(EPOCH_YEAR); k < yr; k++)
				num += days_in_year(k);
			for (k = 1; k < mo; k++)
				num += days_in_month(yr, k);
		end else begin
			num = 32'(w.day_number);
			left = num;
			yr = 32'(EPOCH_YEAR);
			while (yr <= 32'(LAST_YEAR) && left >= days_in_year(yr)) begin
				left -= days_in_year(yr);
				yr++;
			end
			if (yr > 32'(LAST_YEAR))
				return r;
			mo = 1;
			while (mo <= 12 && left >= days_in_month(yr, mo)) begin
				left -= days_in_month(yr, mo);
				mo++;
			end
			dy = left + 1;
		end
		r.valid_res = 1'b1;
		r.day_count = 16'(num);
		r.out_year  = 12'(yr);
		r.out_month = 4'(mo);
		r.out_day   = 5'(dy);
		r.weekday   = 3'((32'(EPOCH_WEEKDAY) + num) % 7);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
		input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("response word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					compare_field("valid_res", 32'(rsp.valid_res), 32'(want.valid_res));
					compare_field("day_count", 32'(rsp.day_count), 32'(want.day_count));
					compare_field("out_year", 32'(rsp.out_year), 32'(want.out_year));
					compare_field("out_month", 32'(rsp.out_month), 32'(want.out_month));
					compare_field("out_day", 32'(rsp.out_day), 32'(want.out_day));
					compare_field("weekday", 32'(rsp.weekday), 32'(want.weekday));
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_words.push_back(convert_calendar(cmd));
			outstanding <= expected_words.size();
		end
	end

endmodule

/* verif/calendar_day_number_converter_test.sv */
// Testbench top for the calendar day number converter: clock, reset, command stimulus
// and random response stalls; checking lives in day_number_checker.
// Depends on cdn_pkg, day_number_checker and the converter RTL.

module calendar_day_number_converter_test import cdn_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted word before the run is declared hung. Given
	// the pipeline depth and the random response stalls, this is many times the
	// slowest correct gap.
	localparam int HANG_LIMIT = 2000;
	localparam int RANDOM_WORDS = 500;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// High while both sides must run flat out with no idling.
	logic steady = 1'b0;
	int   fail_count;
	int   outstanding;
	int   quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	calendar_day_number_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	day_number_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Stall the response channel in about one cycle in five, except in the
	// steady stretch where every response word is taken at once.
	always @(posedge clk) begin
		if (steady)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(99) < 20);
	end

	// Count cycles in which neither channel moves a word; give up on a hang.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == HANG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Build a date-to-number word; fill the unused day number with noise.
	function automatic cmd_word_t date_word(input int unsigned y, input int unsigned m,
		input int unsigned d);
		cmd_word_t w;
		w.func       = FUNC_TO_NUM;
		w.year       = 12'(y);
		w.month      = 4'(m);
		w.day        = 5'(d);
		w.day_number = 16'($urandom());
		return w;
	endfunction

	// Build a number-to-date word; fill the unused date fields with noise.
	function automatic cmd_word_t number_word(input int unsigned n);
		cmd_word_t w;
		w.func       = FUNC_TO_DATE;
		w.year       = 12'($urandom());
		w.month      = 4'($urandom());
		w.day        = 5'($urandom());
		w.day_number = 16'(n);
		return w;
	endfunction

	// Offer one command word: idle first at random, then hold valid and the
	// payload until the block takes the word. Valid never looks at stall.
	task automatic send_word(input cmd_word_t w);
		while (!steady && $urandom_range(99) < 20) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int unsigned pick;
		cmd_word_t w;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: range ends, leap rules, invalid dates and numbers.
		send_word(date_word(2000, 1, 1));       // epoch, day 0, a Saturday
		send_word(date_word(2099, 12, 31));     // last day in range
		send_word(date_word(2000, 2, 29));      // leap by the four hundred rule
		send_word(date_word(2004, 2, 29));      // ordinary leap year
		send_word(date_word(2001, 2, 29));      // no such day in a common year
		send_word(date_word(2001, 2, 28));
		send_word(date_word(1999, 12, 31));     // year below range
		send_word(date_word(2100, 1, 1));       // year above range
		send_word(date_word(4095, 15, 31));     // every date bit set
		send_word(date_word(0, 0, 0));          // every date bit clear
		send_word(date_word(2050, 0, 10));      // month zero
		send_word(date_word(2050, 13, 10));     // month past December
		send_word(date_word(2050, 6, 0));       // day zero
		send_word(date_word(2050, 4, 31));      // past the end of a short month
		send_word(date_word(2024, 12, 31));
		send_word(number_word(0));
		send_word(number_word(59));             // 2000-02-29
		send_word(number_word(60));
		send_word(number_word(1460));
		send_word(number_word(1461));
		send_word(number_word(36524));          // last number in range
		send_word(number_word(36525));          // first number out of range
		send_word(number_word(65535));

		// Random words: mostly well-formed dates and in-range numbers, with a
		// share of raw noise. Run flat out for a stretch in the middle.
		for (i = 0; i < RANDOM_WORDS; i++) begin
			steady <= (i >= 200 && i < 300);
			pick = $urandom_range(99);
			if (pick < 40) begin
				w = date_word($urandom_range(2099, 2000), $urandom_range(12, 1),
					($urandom_range(99) < 60) ? $urandom_range(28, 1)
						: $urandom_range(31, 29));
			end else if (pick < 55) begin
				w = date_word($urandom_range(4095, 0), $urandom_range(15, 0),
					$urandom_range(31, 0));
			end else if (pick < 90) begin
				w = number_word($urandom_range(36524, 0));
			end else begin
				w = number_word($urandom_range(65535, 0));
			end
			send_word(w);
		end
		cmd_valid <= 1'b0;
		steady <= 1'b0;

		// Drain: let the count take in the last word, wait for every expected
		// response, then let the pipeline settle.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
